FILE: hdl/bsa_pkg.sv
// Shared command, status and beat types of the bitmap slot allocator.
package bsa_pkg;

  localparam int HANDLE_W = 13;

  typedef logic [HANDLE_W-1:0] handle_t;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_UNALLOC = 2'd3
  } status_t;

  typedef struct packed {
    cmd_op_t op;
    logic    in_range;
    handle_t idx;
    handle_t word;
    logic    wv;
  } cmd_t;

  typedef struct packed {
    handle_t granted;
    logic    data_bit;
    status_t status;
    handle_t used;
  } rsp_t;

endpackage

FILE: hdl/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: front end, back end and result queue.
// The allocator holds CAPACITY entries, each with a free bit and one data bit, in a RAM
// of CAPACITY/WORD_BITS words, rounded up. After reset a clearing pass writes every word,
// one per cycle, and full stays high until the pass is done. A command that touches a word
// (a grant, a free, a read or a write of a data bit) goes through the back end in two
// steps: the word is read from the RAM, then modified and written back. A rejected command
// (allocator full, handle out of range) is answered without a RAM access. Allocation finds
// a word with a free bit through a per-word summary vector, starting at the word of the
// last grant. Each command beat produces exactly one result beat, in order.
module bitmap_slot_allocator #(
  parameter int CAPACITY  = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  command,
  input  logic [12:0] handle,
  input  logic        write_value,
  input  logic        push,
  output logic        full,
  output logic [12:0] granted_handle,
  output logic        data_bit,
  output logic [1:0]  status,
  output logic [12:0] used_count,
  output logic        empty,
  input  logic        pop
);

  bsa_pkg::cmd_t cmd_head;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          clearing;
  logic          rsp_full;
  logic          rsp_push;
  bsa_pkg::rsp_t rsp;
  bsa_pkg::rsp_t rsp_head;

  bsa_front #(
    .CAPACITY (CAPACITY),
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .command    (command),
    .handle     (handle),
    .write_value(write_value),
    .push       (push),
    .full       (full),
    .hold       (clearing),
    .cmd_pop    (cmd_pop),
    .cmd_empty  (cmd_empty),
    .cmd_head   (cmd_head)
  );

  bsa_back #(
    .CAPACITY (CAPACITY),
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_head (cmd_head),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .rsp_full (rsp_full),
    .rsp_push (rsp_push),
    .rsp      (rsp),
    .clearing (clearing)
  );

  bsa_fifo #(
    .WIDTH($bits(bsa_pkg::rsp_t))
  ) u_rsp_q (
    .clk  (clk),
    .rst  (rst),
    .push (rsp_push),
    .din  (rsp),
    .full (rsp_full),
    .pop  (pop),
    .dout (rsp_head),
    .empty(empty)
  );

  assign granted_handle = rsp_head.granted;
  assign data_bit       = rsp_head.data_bit;
  assign status         = rsp_head.status;
  assign used_count     = rsp_head.used;

endmodule

FILE: hdl/bsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bsa_fifo.sv
// Two-entry queue for command and result beats.
module bsa_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

FILE: hdl/bsa_front.sv
// Front end: accepts command beats, range-checks and splits the handle, queues them.
module bsa_front #(
  parameter int CAPACITY  = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            command,
  input  bsa_pkg::handle_t      handle,
  input  logic                  write_value,
  input  logic                  push,
  output logic                  full,
  input  logic                  hold,
  input  logic                  cmd_pop,
  output logic                  cmd_empty,
  output bsa_pkg::cmd_t         cmd_head
);

  localparam int RSH     = 20;
  localparam int RECIP   = ((2 ** RSH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W = 18;
  localparam int PROD_W  = bsa_pkg::HANDLE_W + RECIP_W;

  logic             q_full;
  bsa_pkg::cmd_t    item;
  bsa_pkg::handle_t idx;
  logic [PROD_W-1:0] prod;

  assign full = q_full || hold;
  assign idx  = handle - bsa_pkg::HANDLE_W'(1);
  assign prod = PROD_W'(idx) * PROD_W'(RECIP);

  always_comb begin
    item.op       = bsa_pkg::cmd_op_t'(command);
    item.in_range = (handle != '0) && (32'(handle) <= 32'(CAPACITY));
    item.idx      = idx;
    item.word     = bsa_pkg::HANDLE_W'(prod >> RSH);
    item.wv       = write_value;
  end

  bsa_fifo #(
    .WIDTH($bits(bsa_pkg::cmd_t))
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && !full),
    .din  (item),
    .full (q_full),
    .pop  (cmd_pop),
    .dout (cmd_head),
    .empty(cmd_empty)
  );

endmodule

FILE: hdl/bsa_back.sv
// Back end: bitmap word read-modify-write, free-word summary and allocation count.
module bsa_back #(
  parameter int CAPACITY  = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  bsa_pkg::cmd_t cmd_head,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  logic          rsp_full,
  output logic          rsp_push,
  output bsa_pkg::rsp_t rsp,
  output logic          clearing
);

  localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int CW        = $clog2(CAPACITY + 1);
  localparam int LEFT      = CAPACITY - (NUM_WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LEFT);
  localparam int HW        = bsa_pkg::HANDLE_W;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_ACCESS = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [WW-1:0]       clr_addr, clr_addr_next;
  logic [NUM_WORDS-1:0] nonfull, nonfull_next;
  logic [WW-1:0]       search_word, search_word_next;
  logic [CW-1:0]       count, count_next;
  bsa_pkg::cmd_op_t    cur_op, cur_op_next;
  logic [WW-1:0]       cur_word, cur_word_next;
  logic [BW-1:0]       cur_bit, cur_bit_next;
  logic                cur_wv, cur_wv_next;
  bsa_pkg::handle_t    cur_base, cur_base_next;

  logic                    ram_we;
  logic [WW-1:0]           ram_waddr;
  logic [WW-1:0]           ram_raddr;
  logic [2*WORD_BITS-1:0]  ram_wdata;
  logic [2*WORD_BITS-1:0]  ram_rdata;

  logic [WW-1:0]        pick_hi, pick_lo, alloc_word;
  logic                 found_hi, any_free;
  logic [WORD_BITS-1:0] free_w, data_w, bm, free_clr;
  logic [BW-1:0]        low_bit, sel_bit;
  logic                 is_free;

  assign clearing = (state == ST_CLEAR);
  assign free_w   = ram_rdata[WORD_BITS-1:0];
  assign data_w   = ram_rdata[2*WORD_BITS-1:WORD_BITS];
  assign any_free = |nonfull;

  always_comb begin
    pick_hi  = '0;
    pick_lo  = '0;
    found_hi = 1'b0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (nonfull[i] && (WW'(i) >= search_word)) begin
        pick_hi  = WW'(i);
        found_hi = 1'b1;
      end
      if (nonfull[i]) begin
        pick_lo = WW'(i);
      end
    end
    alloc_word = found_hi ? pick_hi : pick_lo;
  end

  always_comb begin
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_w[i]) begin
        low_bit = BW'(i);
      end
    end
  end

  assign sel_bit  = (cur_op == bsa_pkg::CMD_ALLOC) ? low_bit : cur_bit;
  assign bm       = WORD_BITS'(1) << sel_bit;
  assign free_clr = free_w & ~bm;
  assign is_free  = |(free_w & bm);

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    nonfull_next     = nonfull;
    search_word_next = search_word;
    count_next       = count;
    cur_op_next      = cur_op;
    cur_word_next    = cur_word;
    cur_bit_next     = cur_bit;
    cur_wv_next      = cur_wv;
    cur_base_next    = cur_base;
    ram_we           = 1'b0;
    ram_waddr        = cur_word;
    ram_raddr        = cur_word;
    ram_wdata        = {data_w, free_w};
    cmd_pop          = 1'b0;
    rsp_push         = 1'b0;
    rsp.granted      = '0;
    rsp.data_bit     = 1'b0;
    rsp.status       = bsa_pkg::STAT_OK;
    rsp.used         = HW'(count);

    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = {{WORD_BITS{1'b0}},
                     (clr_addr == WW'(NUM_WORDS - 1)) ? LAST_MASK : {WORD_BITS{1'b1}}};
        nonfull_next[clr_addr] = 1'b1;
        if (clr_addr == WW'(NUM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + WW'(1);
        end
      end
      ST_IDLE: begin
        if (!cmd_empty && !rsp_full) begin
          cmd_pop      = 1'b1;
          cur_op_next  = cmd_head.op;
          cur_wv_next  = cmd_head.wv;
          if (cmd_head.op == bsa_pkg::CMD_ALLOC) begin
            if (!any_free) begin
              rsp_push   = 1'b1;
              rsp.status = bsa_pkg::STAT_FULL;
            end else begin
              ram_raddr     = alloc_word;
              cur_word_next = alloc_word;
              cur_base_next = HW'(32'(alloc_word) * WORD_BITS);
              state_next    = ST_ACCESS;
            end
          end else if (!cmd_head.in_range) begin
            rsp_push   = 1'b1;
            rsp.status = bsa_pkg::STAT_RANGE;
          end else begin
            ram_raddr     = WW'(cmd_head.word);
            cur_word_next = WW'(cmd_head.word);
            cur_bit_next  = BW'(cmd_head.idx - HW'(32'(cmd_head.word) * WORD_BITS));
            state_next    = ST_ACCESS;
          end
        end
      end
      ST_ACCESS: begin
        rsp_push   = 1'b1;
        state_next = ST_IDLE;
        case (cur_op)
          bsa_pkg::CMD_ALLOC: begin
            ram_we                  = 1'b1;
            ram_wdata               = {data_w, free_clr};
            nonfull_next[cur_word]  = |free_clr;
            count_next              = count + CW'(1);
            search_word_next        = cur_word;
            rsp.granted             = cur_base + HW'(low_bit) + HW'(1);
          end
          bsa_pkg::CMD_FREE: begin
            if (is_free) begin
              rsp.status = bsa_pkg::STAT_UNALLOC;
            end else begin
              ram_we                 = 1'b1;
              ram_wdata              = {data_w, free_w | bm};
              nonfull_next[cur_word] = 1'b1;
              count_next             = count - CW'(1);
            end
          end
          bsa_pkg::CMD_READ: begin
            rsp.data_bit = |(data_w & bm);
          end
          default: begin
            if (is_free) begin
              rsp.status = bsa_pkg::STAT_UNALLOC;
            end else begin
              ram_we       = 1'b1;
              ram_wdata    = {cur_wv ? (data_w | bm) : (data_w & ~bm), free_w};
              rsp.data_bit = cur_wv;
            end
          end
        endcase
        rsp.used = HW'(count_next);
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      nonfull     <= '0;
      search_word <= '0;
      count       <= '0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      nonfull     <= nonfull_next;
      search_word <= search_word_next;
      count       <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_op   <= cur_op_next;
    cur_word <= cur_word_next;
    cur_bit  <= cur_bit_next;
    cur_wv   <= cur_wv_next;
    cur_base <= cur_base_next;
  end

  bsa_ram #(
    .WIDTH(2 * WORD_BITS),
    .DEPTH(NUM_WORDS)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

endmodule

FILE: hdl/bsa_checker.sv
// Port-level checks of the bitmap slot allocator, bound to the top level.
module bsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [12:0] granted_handle,
  input logic        data_bit,
  input logic [1:0]  status,
  input logic [12:0] used_count
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue is not empty after reset.");

  a_reset_full: assert property (@(posedge clk) rst |=> full)
    else $error("Input is not held off while the maps are cleared after reset.");

  a_grant_counted: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == bsa_pkg::STAT_OK && granted_handle != 13'd0) |-> used_count != 13'd0)
    else $error("A granted handle shows a zero used count.");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == bsa_pkg::STAT_RANGE || status == bsa_pkg::STAT_FULL))
      |-> (granted_handle == 13'd0 && data_bit == 1'b0))
    else $error("A rejected command carries a handle or a data bit.");

  a_beat_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(granted_handle) && $stable(status)
                          && $stable(used_count) && $stable(data_bit)))
    else $error("A waiting result beat changed before it was taken.");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);
